[design/joystick_axis_scale_button_oneshot_unit_assert.svh]
// Assertion macros shared by the joystick scaler RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef JOYSTICK_AXIS_SCALE_BUTTON_ONESHOT_UNIT_ASSERT_SVH
`define JOYSTICK_AXIS_SCALE_BUTTON_ONESHOT_UNIT_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define JAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define JAS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/jas_pkg.sv]
// Package for the joystick scaler: payload structs, register indexes, state enum.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package jas_pkg;

    localparam int AXIS_W   = 16;
    localparam int BTN_W    = 4;
    localparam int BNUM_W   = 3;
    localparam int POS_W    = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_A_W  = 3;
    // 100 * (axis difference) needs seven more bits than the axis.
    localparam int NUM_W    = AXIS_W + 7;

    localparam logic [POS_W-1:0] POS_MAX = 7'd100;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [CFG_A_W-1:0] CFG_ENABLED = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_AUTO_REP = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_X_MIN   = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_X_MAX   = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_Y_MIN   = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_Y_MAX   = 3'd5;

    typedef struct packed {
        logic              opcode;
        logic [AXIS_W-1:0] raw_x;
        logic [AXIS_W-1:0] raw_y;
        logic [BTN_W-1:0]  raw_buttons;
        logic              unplugged;
        logic [BNUM_W-1:0] button_number;
    } t_in_item;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position_x;
        logic [POS_W-1:0] position_y;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

[design/jas_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module jas_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             borrow;

    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_den};
    assign borrow  = trial[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= borrow ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ~borrow};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

[design/joystick_axis_scale_button_oneshot_unit.sv]
// Top level of the joystick scaler: configuration, sequencer, button logic, output register.
// Depends on jas_pkg, jas_div and the assertion macro header.
// A sample passes through decode, prep and two 23-step bit-serial divisions in jas_div,
// one per axis, before its result is registered; no new item is taken until then.
// An axis with equal extents skips its division.
// A button query or a rejected sample goes from decode straight to the finish state.
// Synchronous active-low reset clears control state, configuration, button state and the stored positions.
`timescale 1ns / 1ps

module joystick_axis_scale_button_oneshot_unit
    import jas_pkg::*;
#(
    parameter int BUTTON_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata
);

    `include "joystick_axis_scale_button_oneshot_unit_assert.svh"

    t_state r_state;
    t_state n_state;

    logic              r_enabled;
    logic              r_auto;
    logic [AXIS_W-1:0] r_x_min;
    logic [AXIS_W-1:0] r_x_max;
    logic [AXIS_W-1:0] r_y_min;
    logic [AXIS_W-1:0] r_y_max;

    logic [POS_W-1:0]        r_scaled_x;
    logic [POS_W-1:0]        r_scaled_y;
    logic [BUTTON_COUNT-1:0] r_latched;
    logic [BUTTON_COUNT-1:0] r_serviced;
    logic [BUTTON_COUNT-1:0] n_latched;
    logic [BUTTON_COUNT-1:0] n_serviced;

    t_in_item         r_item;
    logic             r_do_sample;
    logic             r_axis;
    logic             r_neg;
    logic [POS_W-1:0] r_new_x;
    logic [POS_W-1:0] r_new_y;

    logic      r_out_valid;
    t_out_item r_out;

    logic in_acc;
    logic out_free;
    logic fin;
    logic div_start;
    logic fin_ok;
    logic down;

    logic [AXIS_W-1:0] sel_raw;
    logic [AXIS_W-1:0] sel_lo;
    logic [AXIS_W-1:0] sel_hi;
    logic [AXIS_W:0]   diff_n;
    logic [AXIS_W:0]   diff_d;
    logic [AXIS_W:0]   abs_n;
    logic [AXIS_W:0]   abs_d;
    logic [NUM_W-1:0]  mag_n;
    logic [NUM_W-1:0]  num100;
    logic              d_zero;
    logic              neg;

    logic [NUM_W-1:0] div_quo;
    logic             div_done;
    logic [POS_W-1:0] div_val;

    logic [31:0]             btn_wide;
    logic [BUTTON_COUNT-1:0] btn_raw;
    logic [BUTTON_COUNT-1:0] sel;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Axis operands for the current pass: X first, then Y.
    assign sel_raw = r_axis ? r_item.raw_y : r_item.raw_x;
    assign sel_lo  = r_axis ? r_y_min : r_x_min;
    assign sel_hi  = r_axis ? r_y_max : r_x_max;
    assign diff_n  = {1'b0, sel_raw} - {1'b0, sel_lo};
    assign diff_d  = {1'b0, sel_hi} - {1'b0, sel_lo};
    assign abs_n   = diff_n[AXIS_W] ? (~diff_n + (AXIS_W+1)'(1)) : diff_n;
    assign abs_d   = diff_d[AXIS_W] ? (~diff_d + (AXIS_W+1)'(1)) : diff_d;
    assign mag_n   = NUM_W'(abs_n[AXIS_W-1:0]);
    assign num100  = (mag_n << 6) + (mag_n << 5) + (mag_n << 2);
    assign d_zero  = (diff_d == '0);
    // Opposite signs give a quotient at or below zero, which clamps to zero.
    assign neg     = diff_n[AXIS_W] ^ diff_d[AXIS_W];

    jas_div #(
        .NUM_W (NUM_W),
        .DEN_W (AXIS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num100),
        .i_den   (abs_d[AXIS_W-1:0]),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    assign div_val = r_neg ? '0 :
                     ((div_quo > NUM_W'(POS_MAX)) ? POS_MAX : div_quo[POS_W-1:0]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_enabled && (r_item.opcode == OP_SAMPLE) && !r_item.unplugged) begin
                    n_state = ST_PREP;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_PREP: begin
                if (!d_zero) begin
                    n_state = ST_DIV;
                end else if (r_axis) begin
                    n_state = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_done) n_state = r_axis ? ST_FINISH : ST_PREP;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        div_start  = (r_state == ST_PREP) && !d_zero;
        fin        = (r_state == ST_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_auto    <= 1'b1;
            r_x_min   <= '0;
            r_x_max   <= '0;
            r_y_min   <= '0;
            r_y_max   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ENABLED:  r_enabled <= i_cfg_wdata[0];
                CFG_AUTO_REP: r_auto    <= i_cfg_wdata[0];
                CFG_X_MIN:    r_x_min   <= i_cfg_wdata[AXIS_W-1:0];
                CFG_X_MAX:    r_x_max   <= i_cfg_wdata[AXIS_W-1:0];
                CFG_Y_MIN:    r_y_min   <= i_cfg_wdata[AXIS_W-1:0];
                CFG_Y_MAX:    r_y_max   <= i_cfg_wdata[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer data path.
    always_ff @(posedge i_clk) begin
        if (in_acc) r_item <= i_in_data;
        unique case (r_state)
            ST_DECODE: begin
                r_do_sample <= r_enabled && (r_item.opcode == OP_SAMPLE)
                               && !r_item.unplugged;
                r_axis  <= 1'b0;
                r_new_x <= r_scaled_x;
                r_new_y <= r_scaled_y;
            end
            ST_PREP: begin
                r_neg <= neg;
                if (d_zero) r_axis <= 1'b1;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_axis) begin
                        r_new_y <= div_val;
                    end else begin
                        r_new_x <= div_val;
                    end
                    r_axis <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Button handling.
    assign btn_wide = 32'(r_item.raw_buttons);
    assign btn_raw  = btn_wide[BUTTON_COUNT-1:0];

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            sel[i] = (32'(r_item.button_number) == 32'(i) + 32'd1);
        end
    end

    assign down = |(r_latched & sel);

    always_comb begin
        n_latched  = r_latched;
        n_serviced = r_serviced;
        fin_ok     = 1'b0;
        if (r_do_sample) begin
            n_latched  = btn_raw;
            n_serviced = r_serviced & btn_raw;
            fin_ok     = 1'b1;
        end else if (r_enabled && (r_item.opcode == OP_QUERY)) begin
            n_latched = r_latched & ~sel;
            // Without autorepeat a held button that was already reported reads as up.
            if (!(down && !r_auto && (|(r_serviced & sel)))) begin
                if (down) n_serviced = r_serviced | sel;
                fin_ok = down;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched  <= '0;
            r_serviced <= '0;
            r_scaled_x <= '0;
            r_scaled_y <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == CFG_AUTO_REP)) begin
                r_latched  <= '0;
                r_serviced <= '0;
            end else if (fin) begin
                r_latched  <= n_latched;
                r_serviced <= n_serviced;
            end
            if (fin) begin
                r_scaled_x <= r_new_x;
                r_scaled_y <= r_new_y;
            end
        end
    end

    // Output register; a finished transaction waits here while the next one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out.ok         <= fin_ok;
            r_out.position_x <= r_new_x;
            r_out.position_y <= r_new_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `JAS_ASSERT(a_pos_range, (r_scaled_x <= POS_MAX) && (r_scaled_y <= POS_MAX), "position out of range")
    `JAS_ASSERT_IMPL(a_done_in_div, div_done, r_state == ST_DIV, "divider finished outside a division")
    `JAS_ASSERT(a_div_timing, div_start |-> ##(NUM_W + 1) div_done, "divider finish misplaced")
    `JAS_ASSERT(a_serviced_sub, (fin && r_do_sample) |=> ((r_serviced & ~r_latched) == '0), "released button still serviced")

endmodule
